FILE: design/tmis_pkg.sv
`timescale 1ns / 1ps

package tmis_pkg;

   // Program address space: the instruction pointer wraps at this many words.
   localparam int PROGRAM_WORDS = 4096;
   localparam int PC_W          = $clog2(PROGRAM_WORDS);

   // Width of the traced cell position in each result item.
   localparam int CELL_POS_W = 15;

   // Numeric input range: these codes are shifted down by the digit base.
   localparam logic [7:0] NUM_FIRST = 8'd48;
   localparam logic [7:0] NUM_LAST  = 8'd58;
   localparam logic [7:0] NUM_BASE  = 8'd48;

   // Raw opcode values as they arrive from the loader.
   localparam logic [3:0] OP_RIGHT = 4'd0;
   localparam logic [3:0] OP_LEFT  = 4'd1;
   localparam logic [3:0] OP_INC   = 4'd2;
   localparam logic [3:0] OP_DEC   = 4'd3;
   localparam logic [3:0] OP_OPEN  = 4'd4;
   localparam logic [3:0] OP_CLOSE = 4'd5;
   localparam logic [3:0] OP_OUT   = 4'd6;
   localparam logic [3:0] OP_IN    = 4'd7;
   localparam logic [3:0] OP_DEBUG = 4'd8;

   // Decoded command kinds handed from the front end to the back end.
   typedef enum logic [3:0] {
      CMD_RIGHT,
      CMD_LEFT,
      CMD_INC,
      CMD_DEC,
      CMD_OPEN,
      CMD_CLOSE,
      CMD_OUT,
      CMD_IN,
      CMD_DEBUG,
      CMD_UNKNOWN
   } cmd_kind_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_EXEC
   } back_state_type;

   typedef struct packed {
      logic [3:0]      opcode;
      logic [PC_W-1:0] jump_target;
      logic [7:0]      in_byte;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]       next_address;
      logic                  out_valid;
      logic [7:0]            out_byte;
      logic                  debug_on;
      logic [CELL_POS_W-1:0] cell_position;
      logic                  unknown_opcode;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type    kind;
      logic [PC_W-1:0] jump_target;
      logic [7:0]      store_byte;
   } cmd_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic    avail;
      cmd_type cmd;
   } cmd_offer_type;

   // Control returned from the back end to the front end.
   typedef struct packed {
      logic take;
      logic clearing;
   } back_ctl_type;

endpackage

FILE: design/tmis_queue.sv
`timescale 1ns / 1ps

module tmis_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full  = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign rdata = slot_ff[rd_ptr_ff];
   assign do_wr = push & ~full;
   assign do_rd = pop & ~empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: design/tmis_front.sv
`timescale 1ns / 1ps

module tmis_front import tmis_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  req_type       req_item,
   input  logic          numeric_mode,
   input  back_ctl_type  ctl,
   output cmd_offer_type offer
);

   localparam int CMD_W = $bits(cmd_type);

   cmd_type          cmd_dec;
   logic             q_full;
   logic             q_empty;
   logic [CMD_W-1:0] q_rdata;

   // Opcode classification.
   always_comb begin
      unique case (req_item.opcode)
         OP_RIGHT: cmd_dec.kind = CMD_RIGHT;
         OP_LEFT:  cmd_dec.kind = CMD_LEFT;
         OP_INC:   cmd_dec.kind = CMD_INC;
         OP_DEC:   cmd_dec.kind = CMD_DEC;
         OP_OPEN:  cmd_dec.kind = CMD_OPEN;
         OP_CLOSE: cmd_dec.kind = CMD_CLOSE;
         OP_OUT:   cmd_dec.kind = CMD_OUT;
         OP_IN:    cmd_dec.kind = CMD_IN;
         OP_DEBUG: cmd_dec.kind = CMD_DEBUG;
         default:  cmd_dec.kind = CMD_UNKNOWN;
      endcase
      cmd_dec.jump_target = req_item.jump_target;
      // In numeric mode the codes NUM_FIRST to NUM_LAST (the digits and ':') are turned into values 0 to 10.
      if (numeric_mode && (req_item.in_byte >= NUM_FIRST) &&
          (req_item.in_byte <= NUM_LAST)) begin
         cmd_dec.store_byte = req_item.in_byte - NUM_BASE;
      end else begin
         cmd_dec.store_byte = req_item.in_byte;
      end
   end

   // No item is taken while the tape is still being cleared.
   assign full = q_full | ctl.clearing;

   tmis_queue #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push & ~ctl.clearing),
      .full  (q_full),
      .wdata (cmd_dec),
      .pop   (ctl.take),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   assign offer.avail = ~q_empty;
   assign offer.cmd   = cmd_type'(q_rdata);

endmodule

FILE: design/tmis_back.sv
`timescale 1ns / 1ps

module tmis_back import tmis_pkg::*; #(
   parameter int TAPE_CELLS = 32768
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_offer_type offer,
   output back_ctl_type  ctl,
   input  logic          rsp_full,
   output logic          rsp_push,
   output rsp_type       rsp_item
);

   localparam int ADDR_W = $clog2(TAPE_CELLS);
   localparam logic [ADDR_W-1:0] CP_LAST = ADDR_W'(TAPE_CELLS - 1);

   back_state_type  state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] cp_ff, cp_in;
   logic [PC_W-1:0]   ip_ff, ip_in;
   logic              dbg_ff, dbg_in;
   cmd_type           cmd_ff;
   logic [7:0]        rd_ff;

   logic [7:0]        tape_mem [TAPE_CELLS];
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        mem_wdata;

   logic              start;
   logic [ADDR_W-1:0] exec_cp;
   logic [PC_W-1:0]   exec_ip;
   logic              exec_dbg;
   logic              exec_we;
   logic [7:0]        exec_byte;
   logic              exec_jump;

   assign start = (state_ff == BACK_IDLE) && offer.avail && !rsp_full;

   // Next state.
   always_comb begin
      unique case (state_ff)
         BACK_CLEAR: state_in = (clr_ff == CP_LAST) ? BACK_IDLE : BACK_CLEAR;
         BACK_IDLE:  state_in = start ? BACK_EXEC : BACK_IDLE;
         BACK_EXEC:  state_in = BACK_IDLE;
         default:    state_in = BACK_CLEAR;
      endcase
   end

   // Execution of the held command against the cell that was read.
   always_comb begin
      exec_cp   = cp_ff;
      exec_dbg  = dbg_ff;
      exec_we   = 1'b0;
      exec_byte = rd_ff;
      exec_jump = 1'b0;
      unique case (cmd_ff.kind)
         CMD_RIGHT: exec_cp = (cp_ff == CP_LAST) ? '0 : cp_ff + ADDR_W'(1);
         CMD_LEFT:  exec_cp = (cp_ff == '0) ? CP_LAST : cp_ff - ADDR_W'(1);
         CMD_INC: begin
            exec_we   = 1'b1;
            exec_byte = rd_ff + 8'd1;
         end
         CMD_DEC: begin
            exec_we   = 1'b1;
            exec_byte = rd_ff - 8'd1;
         end
         CMD_OPEN:  exec_jump = (rd_ff == 8'd0);
         CMD_CLOSE: exec_jump = (rd_ff != 8'd0);
         CMD_IN: begin
            exec_we   = 1'b1;
            exec_byte = cmd_ff.store_byte;
         end
         CMD_DEBUG: exec_dbg = ~dbg_ff;
         default:   exec_cp = cp_ff;
      endcase
      exec_ip = (exec_jump ? cmd_ff.jump_target : ip_ff) + PC_W'(1);
   end

   // Result item built in the execute cycle.
   always_comb begin
      rsp_item.next_address   = exec_ip;
      rsp_item.out_valid      = (cmd_ff.kind == CMD_OUT);
      rsp_item.out_byte       = (cmd_ff.kind == CMD_OUT) ? rd_ff : 8'd0;
      rsp_item.debug_on       = exec_dbg;
      rsp_item.cell_position  = CELL_POS_W'(exec_cp);
      rsp_item.unknown_opcode = (cmd_ff.kind == CMD_UNKNOWN);
   end

   // Outputs of the sequencer.
   always_comb begin
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = cp_ff;
      mem_wdata    = exec_byte;
      ctl.take     = 1'b0;
      ctl.clearing = 1'b0;
      rsp_push     = 1'b0;
      clr_in       = clr_ff;
      cp_in        = cp_ff;
      ip_in        = ip_ff;
      dbg_in       = dbg_ff;
      unique case (state_ff)
         BACK_CLEAR: begin
            mem_we       = 1'b1;
            mem_addr     = clr_ff;
            mem_wdata    = 8'd0;
            ctl.clearing = 1'b1;
            clr_in       = clr_ff + ADDR_W'(1);
         end
         BACK_IDLE: begin
            ctl.take = start;
            mem_re   = start;
         end
         BACK_EXEC: begin
            mem_we   = exec_we;
            rsp_push = 1'b1;
            cp_in    = exec_cp;
            ip_in    = exec_ip;
            dbg_in   = exec_dbg;
         end
         default: begin
            ctl.clearing = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_CLEAR;
         clr_ff   <= '0;
         cp_ff    <= '0;
         ip_ff    <= '0;
         dbg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cp_ff    <= cp_in;
         ip_ff    <= ip_in;
         dbg_ff   <= dbg_in;
      end
   end

   // Command held for the execute cycle.
   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff <= offer.cmd;
      end
   end

   // Tape memory: one access per cycle, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tape_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= tape_mem[mem_addr];
      end
   end

endmodule

FILE: design/tape_machine_instruction_step.sv
`timescale 1ns / 1ps

// Executes one instruction of a nine-command tape machine for each item
// pushed in, and queues one result item per instruction. In the execute
// unit each instruction first reads the current tape cell from the
// single-port tape memory and then writes it back and forms the result,
// and no new command is taken before the last one is through; a two-entry
// command queue in front and a two-entry result queue behind let the input
// and the output stall independently. After reset the tape memory is
// cleared one cell per cycle, and full stays high until the clear is done;
// the numeric input mode register can be written throughout. The
// instruction pointer wraps at 4096 words and the cell pointer at
// TAPE_CELLS cells.
module tape_machine_instruction_step import tmis_pkg::*; #(
   parameter int TAPE_CELLS = 32768
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int RSP_W = $bits(rsp_type);

   logic             numeric_ff;
   cmd_offer_type    cmd_offer;
   back_ctl_type     back_ctl;
   logic             rsp_push;
   logic             rsp_full;
   rsp_type          rsp_item;
   logic [RSP_W-1:0] rsp_rdata;

   // Numeric input mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         numeric_ff <= 1'b0;
      end else if (csr_wr_en) begin
         numeric_ff <= csr_wr_data;
      end
   end

   tmis_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_item     (req_data),
      .numeric_mode (numeric_ff),
      .ctl          (back_ctl),
      .offer        (cmd_offer)
   );

   tmis_back #(
      .TAPE_CELLS (TAPE_CELLS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .offer    (cmd_offer),
      .ctl      (back_ctl),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item)
   );

   tmis_queue #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .wdata (rsp_item),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_rdata)
   );

   assign rsp_data = rsp_type'(rsp_rdata);

   // The tape clear keeps the input closed.
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      back_ctl.clearing |-> full)
      else $error("item could be accepted during tape clear");

   // Every command taken by the execute unit yields a result in the next cycle.
   a_one_result_per_cmd: assert property (@(posedge clock) disable iff (reset)
      back_ctl.take |=> rsp_push)
      else $error("taken command produced no result");

   // The execute unit only starts when the result queue has room.
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   // A command is only taken when one is waiting.
   a_take_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      back_ctl.take |-> cmd_offer.avail)
      else $error("command taken from an empty queue");

endmodule
